FILE: design/vrd_pkg.sv
// ----------------------------------------------------------------------------
// vrd_pkg
// Shared widths, constants, arctangent table and control types for the
// degree-based cordic vector rotator.
// ----------------------------------------------------------------------------
package vrd_pkg;

    localparam int STAGES_DEF = 20;

    localparam int VEC_W  = 32;
    localparam int ANG_W  = 17;
    localparam int FOLD_W = 18;
    localparam int REM_W  = 14;
    localparam int CW     = 42;
    localparam int ZW     = 34;
    localparam int PROD_W = 65;
    localparam int IDX_W  = 5;
    localparam int GUARD  = 8;
    localparam int PRE_SH = 24;
    localparam int Z_SH   = 17;

    localparam logic signed [32:0] KINV = 33'sd2608131496;
    localparam logic signed [PROD_W-1:0] PRE_RND = PROD_W'(64'sd8388608);
    localparam logic signed [CW-1:0] POST_RND = CW'(64'sd128);

    localparam logic signed [FOLD_W-1:0] FULL_TURN = 18'sd46080;
    localparam logic signed [FOLD_W-1:0] QTR_1     = 18'sd11520;
    localparam logic signed [FOLD_W-1:0] QTR_2     = 18'sd23040;
    localparam logic signed [FOLD_W-1:0] QTR_3     = 18'sd34560;

    localparam logic signed [ZW-VEC_W+GUARD-1+VEC_W-GUARD:0] SAT_MAX = 34'sd2147483647;
    localparam logic signed [ZW-1:0] SAT_MIN = -34'sd2147483648;

    localparam logic [ZW-1:0] ATAN_TAB [32] = '{
        34'd754974720, 34'd445687602, 34'd235489089, 34'd119537938,
        34'd60000934,  34'd30029717,  34'd15018523,  34'd7509720,
        34'd3754917,   34'd1877466,   34'd938734,    34'd469367,
        34'd234684,    34'd117342,    34'd58671,     34'd29335,
        34'd14668,     34'd7334,      34'd3667,      34'd1833,
        34'd917,       34'd458,       34'd229,       34'd115,
        34'd57,        34'd29,        34'd14,        34'd7,
        34'd4,         34'd2,         34'd1,         34'd0
    };

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef struct packed {
        logic  valid;
        t_quad quad;
    } t_ctl;

endpackage

FILE: design/vector_rotate_degrees_core.sv
// ----------------------------------------------------------------------------
// vector_rotate_degrees_core
// Rotates a Q16.16 vector by a signed angle in 1/128 degree steps using a
// pipelined cordic with quadrant folding and gain prescale.
// ----------------------------------------------------------------------------
// usage:
//   a word (i_vec_x, i_vec_y, i_angle_deg) is taken on each rising edge
//   where start is high and busy is low; busy stays low, so a new word can
//   be offered on every cycle
//   the rotated word appears on o_rot_x / o_rot_y with o_valid high for
//   exactly one cycle, CORDIC_STAGES + 4 cycles after it was taken
//   stages: two for angle fold and gain prescale (one multiplier per
//   component), one per cordic cell, two for quadrant turn and rounding
//   throughput is one word per cycle, set by the fully pipelined cell row
//   the receiver cannot stall: every result is shown once and must be taken
//   angles outside +-360 degrees wrap; outputs saturate at 32-bit limits
//   synchronous reset empties the pipeline; words in flight are dropped
// ----------------------------------------------------------------------------
module vector_rotate_degrees_core #(
    parameter int CORDIC_STAGES = vrd_pkg::STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [vrd_pkg::VEC_W-1:0]    i_vec_x,
    input  logic signed [vrd_pkg::VEC_W-1:0]    i_vec_y,
    input  logic signed [vrd_pkg::ANG_W-1:0]    i_angle_deg,
    output logic                                o_valid,
    output logic signed [vrd_pkg::VEC_W-1:0]    o_rot_x,
    output logic signed [vrd_pkg::VEC_W-1:0]    o_rot_y
);

    localparam int LAT = CORDIC_STAGES + 4;

    vrd_pkg::t_ctl                 c_ctl [CORDIC_STAGES+1];
    logic signed [vrd_pkg::CW-1:0] c_x   [CORDIC_STAGES+1];
    logic signed [vrd_pkg::CW-1:0] c_y   [CORDIC_STAGES+1];
    logic signed [vrd_pkg::ZW-1:0] c_z   [CORDIC_STAGES+1];

    assign busy = 1'b0;

    vrd_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_angle_deg (i_angle_deg),
        .o_ctl       (c_ctl[0]),
        .o_x         (c_x[0]),
        .o_y         (c_y[0]),
        .o_z         (c_z[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        vrd_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1])
        );
    end

    vrd_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (c_ctl[CORDIC_STAGES]),
        .i_x     (c_x[CORDIC_STAGES]),
        .i_y     (c_y[CORDIC_STAGES]),
        .o_valid (o_valid),
        .o_rot_x (o_rot_x),
        .o_rot_y (o_rot_y)
    );

`ifndef SYNTHESIS
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result word without a matching accepted word");

    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(start && !busy && i_vec_x == 0 && i_vec_y == 0, LAT))
        |-> (o_rot_x == 0 && o_rot_y == 0))
        else $error("zero vector did not rotate to zero");

    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe high right after reset");
`endif

endmodule

FILE: design/vrd_prep.sv
// ----------------------------------------------------------------------------
// vrd_prep
// Folds the angle into a quarter turn plus residual and prescales the vector
// by the inverse cordic gain, over two register stages.
// ----------------------------------------------------------------------------
module vrd_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [vrd_pkg::VEC_W-1:0]    i_vec_x,
    input  logic signed [vrd_pkg::VEC_W-1:0]    i_vec_y,
    input  logic signed [vrd_pkg::ANG_W-1:0]    i_angle_deg,
    output vrd_pkg::t_ctl                       o_ctl,
    output logic signed [vrd_pkg::CW-1:0]       o_x,
    output logic signed [vrd_pkg::CW-1:0]       o_y,
    output logic signed [vrd_pkg::ZW-1:0]       o_z
);

    logic signed [vrd_pkg::FOLD_W-1:0] a_ext;
    logic signed [vrd_pkg::FOLD_W-1:0] m_pre;
    logic signed [vrd_pkg::FOLD_W-1:0] m_fold;
    logic signed [vrd_pkg::FOLD_W-1:0] m_rem;
    vrd_pkg::t_quad                    n_quad;
    logic signed [vrd_pkg::PROD_W-1:0] n_px;
    logic signed [vrd_pkg::PROD_W-1:0] n_py;
    logic signed [vrd_pkg::PROD_W-1:0] sum_x;
    logic signed [vrd_pkg::PROD_W-1:0] sum_y;

    vrd_pkg::t_ctl                     r_ctl1;
    logic signed [vrd_pkg::PROD_W-1:0] r_px;
    logic signed [vrd_pkg::PROD_W-1:0] r_py;
    logic [vrd_pkg::REM_W-1:0]         r_rem;
    vrd_pkg::t_ctl                     r_ctl2;
    logic signed [vrd_pkg::CW-1:0]     r_x;
    logic signed [vrd_pkg::CW-1:0]     r_y;
    logic signed [vrd_pkg::ZW-1:0]     r_z;

    // angle modulo a full turn, then quarter and residual
    always_comb begin
        a_ext = vrd_pkg::FOLD_W'(i_angle_deg);
        if (a_ext < 0) begin
            m_pre = a_ext + vrd_pkg::FULL_TURN;
        end else if (a_ext >= vrd_pkg::FULL_TURN) begin
            m_pre = a_ext - vrd_pkg::FULL_TURN;
        end else begin
            m_pre = a_ext;
        end
        m_fold = (m_pre < 0) ? (m_pre + vrd_pkg::FULL_TURN) : m_pre;
        priority if (m_fold >= vrd_pkg::QTR_3) begin
            n_quad = vrd_pkg::QUAD_3;
            m_rem  = m_fold - vrd_pkg::QTR_3;
        end else if (m_fold >= vrd_pkg::QTR_2) begin
            n_quad = vrd_pkg::QUAD_2;
            m_rem  = m_fold - vrd_pkg::QTR_2;
        end else if (m_fold >= vrd_pkg::QTR_1) begin
            n_quad = vrd_pkg::QUAD_1;
            m_rem  = m_fold - vrd_pkg::QTR_1;
        end else begin
            n_quad = vrd_pkg::QUAD_0;
            m_rem  = m_fold;
        end
    end

    assign n_px  = i_vec_x * vrd_pkg::KINV;
    assign n_py  = i_vec_y * vrd_pkg::KINV;
    assign sum_x = r_px + vrd_pkg::PRE_RND;
    assign sum_y = r_py + vrd_pkg::PRE_RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
            r_ctl2.valid <= 1'b0;
        end else begin
            r_ctl1.valid <= i_valid;
            r_ctl2.valid <= r_ctl1.valid;
        end
        r_ctl1.quad <= n_quad;
        r_px        <= n_px;
        r_py        <= n_py;
        r_rem       <= m_rem[vrd_pkg::REM_W-1:0];
        r_ctl2.quad <= r_ctl1.quad;
        r_x         <= vrd_pkg::CW'($signed(sum_x[vrd_pkg::PROD_W-1:vrd_pkg::PRE_SH]));
        r_y         <= vrd_pkg::CW'($signed(sum_y[vrd_pkg::PROD_W-1:vrd_pkg::PRE_SH]));
        r_z         <= vrd_pkg::ZW'({r_rem, {vrd_pkg::Z_SH{1'b0}}});
    end

    assign o_ctl = r_ctl2;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

FILE: design/vrd_cell.sv
// ----------------------------------------------------------------------------
// vrd_cell
// One cordic micro-rotation in rotation mode: shift, add or subtract, and
// angle update, registered towards the next cell.
// ----------------------------------------------------------------------------
module vrd_cell #(
    parameter int STAGE = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vrd_pkg::t_ctl                   i_ctl,
    input  logic signed [vrd_pkg::CW-1:0]   i_x,
    input  logic signed [vrd_pkg::CW-1:0]   i_y,
    input  logic signed [vrd_pkg::ZW-1:0]   i_z,
    output vrd_pkg::t_ctl                   o_ctl,
    output logic signed [vrd_pkg::CW-1:0]   o_x,
    output logic signed [vrd_pkg::CW-1:0]   o_y,
    output logic signed [vrd_pkg::ZW-1:0]   o_z
);

    localparam logic [vrd_pkg::IDX_W-1:0] IDX = vrd_pkg::IDX_W'(STAGE);
    localparam logic signed [vrd_pkg::ZW-1:0] ATAN = $signed(vrd_pkg::ATAN_TAB[IDX]);

    logic signed [vrd_pkg::CW-1:0] dx;
    logic signed [vrd_pkg::CW-1:0] dy;
    logic signed [vrd_pkg::CW-1:0] n_x;
    logic signed [vrd_pkg::CW-1:0] n_y;
    logic signed [vrd_pkg::ZW-1:0] n_z;

    vrd_pkg::t_ctl                 r_ctl;
    logic signed [vrd_pkg::CW-1:0] r_x;
    logic signed [vrd_pkg::CW-1:0] r_y;
    logic signed [vrd_pkg::ZW-1:0] r_z;

    assign dx = i_y >>> IDX;
    assign dy = i_x >>> IDX;

    always_comb begin
        if (!i_z[vrd_pkg::ZW-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.quad <= i_ctl.quad;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

FILE: design/vrd_post.sv
// ----------------------------------------------------------------------------
// vrd_post
// Applies the quarter-turn rotation, then drops the guard bits with rounding
// and saturates to the 32-bit output range.
// ----------------------------------------------------------------------------
module vrd_post (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vrd_pkg::t_ctl                       i_ctl,
    input  logic signed [vrd_pkg::CW-1:0]       i_x,
    input  logic signed [vrd_pkg::CW-1:0]       i_y,
    output logic                                o_valid,
    output logic signed [vrd_pkg::VEC_W-1:0]    o_rot_x,
    output logic signed [vrd_pkg::VEC_W-1:0]    o_rot_y
);

    function automatic logic signed [vrd_pkg::VEC_W-1:0] sat_round(
        input logic signed [vrd_pkg::CW-1:0] v
    );
        logic signed [vrd_pkg::CW-1:0] rnd;
        logic signed [vrd_pkg::ZW-1:0] sh;
        rnd = v + vrd_pkg::POST_RND;
        sh  = vrd_pkg::ZW'($signed(rnd[vrd_pkg::CW-1:vrd_pkg::GUARD]));
        if (sh > vrd_pkg::SAT_MAX) begin
            return vrd_pkg::SAT_MAX[vrd_pkg::VEC_W-1:0];
        end else if (sh < vrd_pkg::SAT_MIN) begin
            return vrd_pkg::SAT_MIN[vrd_pkg::VEC_W-1:0];
        end
        return sh[vrd_pkg::VEC_W-1:0];
    endfunction

    logic signed [vrd_pkg::CW-1:0] n_qx;
    logic signed [vrd_pkg::CW-1:0] n_qy;

    logic                              r_valid1;
    logic signed [vrd_pkg::CW-1:0]     r_qx;
    logic signed [vrd_pkg::CW-1:0]     r_qy;
    logic                              r_valid2;
    logic signed [vrd_pkg::VEC_W-1:0]  r_rot_x;
    logic signed [vrd_pkg::VEC_W-1:0]  r_rot_y;

    always_comb begin
        unique case (i_ctl.quad)
            vrd_pkg::QUAD_1: begin
                n_qx = -i_y;
                n_qy = i_x;
            end
            vrd_pkg::QUAD_2: begin
                n_qx = -i_x;
                n_qy = -i_y;
            end
            vrd_pkg::QUAD_3: begin
                n_qx = i_y;
                n_qy = -i_x;
            end
            default: begin
                n_qx = i_x;
                n_qy = i_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_ctl.valid;
            r_valid2 <= r_valid1;
        end
        r_qx    <= n_qx;
        r_qy    <= n_qy;
        r_rot_x <= sat_round(r_qx);
        r_rot_y <= sat_round(r_qy);
    end

    assign o_valid = r_valid2;
    assign o_rot_x = r_rot_x;
    assign o_rot_y = r_rot_y;

endmodule

FILE: sim/tb_vector_rotate_degrees_core.sv
// ----------------------------------------------------------------------------
// tb_vector_rotate_degrees_core
// Self-checking bench for the degree-based cordic vector rotator. Words are
// pushed through the start/busy handshake with random idle cycles on the
// sender side. Every accepted word is run through a bit-exact integer model
// of the fold, prescale, cordic, quadrant turn and rounding steps. Each
// strobed result is then compared in order with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_vector_rotate_degrees_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES     = vrd_pkg::STAGES_DEF;
    localparam int XW         = vrd_pkg::VEC_W;
    localparam int AW         = vrd_pkg::ANG_W;
    localparam int QUIET_MAX  = 4000;
    localparam int RAND_WORDS = 300;

    localparam int TURN_UNITS = 46080;
    localparam int QTR_UNITS  = 11520;
    localparam longint signed GAIN_INV = 64'sd2608131496;
    localparam longint signed VEC_MAX  = 64'sd2147483647;
    localparam longint signed VEC_MIN  = -64'sd2147483648;

    // atan(2^-i) in 2^-24 degree steps
    localparam longint signed ARCTAN_DEG [32] = '{
        754974720, 445687602, 235489089, 119537938,
        60000934,  30029717,  15018523,  7509720,
        3754917,   1877466,   938734,    469367,
        234684,    117342,    58671,     29335,
        14668,     7334,      3667,      1833,
        917,       458,       229,       115,
        57,        29,        14,        7,
        4,         2,         1,         0
    };

    class rotation_book;
        typedef struct {
            logic signed [XW-1:0] rx;
            logic signed [XW-1:0] ry;
        } rot_word_t;

        rot_word_t rotated_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function logic signed [XW-1:0] round_sat(longint signed v);
            longint signed r;
            r = (v + 64'sd128) >>> 8;
            if (r > VEC_MAX) r = VEC_MAX;
            if (r < VEC_MIN) r = VEC_MIN;
            return r[XW-1:0];
        endfunction

        function void note_word(logic signed [XW-1:0] vx, logic signed [XW-1:0] vy,
                                logic signed [AW-1:0] ang);
            longint signed px, py, z, dx, dy, t;
            int a, m, r;
            vrd_pkg::t_quad q;
            rot_word_t w;
            a = int'(ang);
            m = a % TURN_UNITS;
            if (m < 0) m += TURN_UNITS;
            q = vrd_pkg::t_quad'(2'(m / QTR_UNITS));
            r = m % QTR_UNITS;
            z = longint'(r) * 64'sd131072;
            px = (longint'(vx) * GAIN_INV + 64'sd8388608) >>> 24;
            py = (longint'(vy) * GAIN_INV + 64'sd8388608) >>> 24;
            for (int i = 0; i < STAGES && i < 32; i++) begin
                dx = py >>> i;
                dy = px >>> i;
                if (z >= 0) begin
                    px -= dx;
                    py += dy;
                    z  -= ARCTAN_DEG[i];
                end else begin
                    px += dx;
                    py -= dy;
                    z  += ARCTAN_DEG[i];
                end
            end
            case (q)
                vrd_pkg::QUAD_1: begin
                    t = px; px = -py; py = t;
                end
                vrd_pkg::QUAD_2: begin
                    px = -px; py = -py;
                end
                vrd_pkg::QUAD_3: begin
                    t = px; px = py; py = -t;
                end
                default: begin
                end
            endcase
            w.rx = round_sat(px);
            w.ry = round_sat(py);
            rotated_q.push_back(w);
        endfunction

        function void check_word(logic signed [XW-1:0] rx, logic signed [XW-1:0] ry);
            rot_word_t w;
            if (rotated_q.size() == 0) begin
                $display("%0t unexpected word: got rot_x %0d rot_y %0d", $time, rx, ry);
                errors++;
                return;
            end
            w = rotated_q.pop_front();
            if (rx !== w.rx) begin
                $display("%0t rot_x mismatch: expected %0d, got %0d", $time, w.rx, rx);
                errors++;
            end
            if (ry !== w.ry) begin
                $display("%0t rot_y mismatch: expected %0d, got %0d", $time, w.ry, ry);
                errors++;
            end
        endfunction

        function int pending();
            return rotated_q.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic signed [XW-1:0] i_vec_x     = '0;
    logic signed [XW-1:0] i_vec_y     = '0;
    logic signed [AW-1:0] i_angle_deg = '0;
    logic                 o_valid;
    logic signed [XW-1:0] o_rot_x;
    logic signed [XW-1:0] o_rot_y;

    rotation_book book = new();
    int           idle_pct = 0;

    vector_rotate_degrees_core #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_angle_deg (i_angle_deg),
        .o_valid     (o_valid),
        .o_rot_x     (o_rot_x),
        .o_rot_y     (o_rot_y)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            book.check_word(o_rot_x, o_rot_y);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid) quiet = 0;
            else quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(logic signed [XW-1:0] vx, logic signed [XW-1:0] vy,
                             logic signed [AW-1:0] ang);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_vec_x     <= vx;
        i_vec_y     <= vy;
        i_angle_deg <= ang;
        do @(posedge i_clk); while (busy);
        book.note_word(vx, vy, ang);
    endtask

    function automatic logic signed [XW-1:0] pick_component();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4) return $urandom();
        if (sel < 7) return XW'(int'($urandom_range(2097152)) - 1048576);
        if (sel < 8) return XW'(32'sh7fff_ffff - int'($urandom_range(255)));
        if (sel < 9) return XW'(32'sh8000_0000 + int'($urandom_range(255)));
        return XW'(int'($urandom_range(131072)) - 65536);
    endfunction

    function automatic logic signed [AW-1:0] pick_angle();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 7) return AW'(int'($urandom_range(92160)) - TURN_UNITS);
        if (sel < 9) return AW'($urandom());
        // near a quadrant boundary
        return AW'(QTR_UNITS * (int'($urandom_range(8)) - 4) + int'($urandom_range(6)) - 3);
    endfunction

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) begin
            send_word(pick_component(), pick_component(), pick_angle());
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 16;
        send_word(32'sd0, 32'sd0, 17'sd0);
        send_word(32'sh7fff_ffff, 32'sh7fff_ffff, 17'sd0);
        send_word(32'sh8000_0000, 32'sh8000_0000, 17'sd0);
        send_word(32'sh7fff_ffff, 32'sh8000_0000, 17'sd11520);
        send_word(32'sh8000_0000, 32'sh7fff_ffff, -17'sd11520);
        send_word(32'sd65536, 32'sd0, 17'sd5760);
        // saturation on a diagonal turn
        send_word(32'sh7fff_ffff, 32'sh7fff_ffff, 17'sd5760);
        send_word(32'sh8000_0000, 32'sh8000_0000, 17'sd5760);
        send_word(32'sh8000_0000, 32'sd0, 17'sd23040);
        send_word(32'sd65536, 32'sd0, 17'sd46080);
        send_word(32'sd65536, 32'sd0, -17'sd46080);
        // angles past a full turn wrap
        send_word(32'sd65536, 32'sd32768, 17'sd65535);
        send_word(32'sd65536, -32'sd32768, -17'sd65536);
        send_word(32'sd65536, 32'sd0, 17'sd34560);
        send_word(32'sd65536, 32'sd0, 17'sd1);
        send_word(32'sd65536, 32'sd0, -17'sd1);
        send_word(-32'sd1, -32'sd1, 17'sd11519);
        send_word(32'sd1, 32'sd1, 17'sd23041);
        send_word(32'sd0, 32'sh8000_0000, -17'sd5760);
        send_word(32'sd123456, -32'sd654321, 17'sd46079);
        send_word(32'sh7fff_ffff, 32'sd0, 17'sd17280);
        run_random(RAND_WORDS);

        idle_pct = 51;
        run_random(RAND_WORDS);

        idle_pct = 0;
        run_random(RAND_WORDS);

        start <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (STAGES + 8) @(posedge i_clk);

        if (book.errors == 0 && book.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
